FILE: sv/camera_block_frame_parser_core_defines.svh
// Shared assertion macros.
`ifndef CAMERA_BLOCK_FRAME_PARSER_CORE_DEFINES_SVH
`define CAMERA_BLOCK_FRAME_PARSER_CORE_DEFINES_SVH

// Same-cycle implication.
`define CBFP_ASSERT_IMPL(name, clk_s, rst_s, ante, cons) \
  name: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error("cbfp assertion failed");

// Next-cycle implication.
`define CBFP_ASSERT_NEXT(name, clk_s, rst_s, ante, cons) \
  name: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error("cbfp assertion failed");

`endif

FILE: sv/cbfp_pkg.sv
package cbfp_pkg;

  localparam int unsigned MAX_OBJECTS = 10;
  localparam int unsigned WORD_W      = 16;
  localparam int unsigned COUNT_W     = 4;
  localparam int unsigned CFG_INDEX_W = 1;

  localparam logic [WORD_W-1:0] SYNC_WORD_RESET      = 16'hAA55;
  localparam logic [WORD_W-1:0] SIGNATURE_WORD_RESET = 16'h0001;

  localparam logic [CFG_INDEX_W-1:0] REG_SYNC_WORD      = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_SIGNATURE_WORD = 1'b1;

  typedef enum logic [6:0] {
    PH_SYNC  = 7'b0000001,
    PH_CHECK = 7'b0000010,
    PH_SIG   = 7'b0000100,
    PH_X     = 7'b0001000,
    PH_Y     = 7'b0010000,
    PH_H     = 7'b0100000,
    PH_W     = 7'b1000000
  } phase_t;

  typedef struct packed {
    logic [WORD_W-1:0] data_word;
    logic              buffer_first;
    logic              buffer_last;
  } word_t;

  typedef struct packed {
    logic               object_valid;
    logic [COUNT_W-1:0] object_index;
    logic [WORD_W-1:0]  pos_x;
    logic [WORD_W-1:0]  pos_y;
    logic [WORD_W-1:0]  obj_height;
    logic [WORD_W-1:0]  obj_width;
    logic               buffer_done;
    logic [COUNT_W-1:0] found_count;
  } result_t;

endpackage

FILE: sv/camera_block_frame_parser_core.sv
// Channel   Direction  Handshake                  Payload
// word      in         word_valid / word_stall    word_t   (one 16-bit word per request)
// result    out        result_valid / result_stall result_t (object and/or buffer count)
// cfg       in         cfg_we                     cfg_index, cfg_data
//
// One word per cycle while word_stall is low; a result appears in the cycle
// after the word that causes it. The parse state and the result register share
// one clock edge, so an accepted word is fully handled with no internal backlog.
// rst is synchronous: parser to sync hunt, count to zero, registers to defaults.
// word_stall is high only while a result is held and result_stall is high.
`include "camera_block_frame_parser_core_defines.svh"

module camera_block_frame_parser_core
  import cbfp_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   word_valid,
  output logic                   word_stall,
  input  word_t                  word,
  output logic                   result_valid,
  input  logic                   result_stall,
  output result_t                result,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [WORD_W-1:0]      cfg_data
);

  logic [WORD_W-1:0]  sync_word;
  logic [WORD_W-1:0]  signature_word;
  phase_t             phase;
  phase_t             phase_cur;
  phase_t             phase_next;
  logic [COUNT_W-1:0] count;
  logic [COUNT_W-1:0] count_cur;
  logic [COUNT_W-1:0] count_next;
  logic [WORD_W-1:0]  expected_sum;
  logic [WORD_W-1:0]  expected_sum_next;
  logic [WORD_W-1:0]  running_sum;
  logic [WORD_W-1:0]  running_sum_next;
  logic [WORD_W-1:0]  held_x;
  logic [WORD_W-1:0]  held_x_next;
  logic [WORD_W-1:0]  held_y;
  logic [WORD_W-1:0]  held_y_next;
  logic [WORD_W-1:0]  held_height;
  logic [WORD_W-1:0]  held_height_next;
  logic [WORD_W-1:0]  sum_w;
  logic               accept;
  logic               emit;
  result_t            result_next;

  assign word_stall = result_valid && result_stall;
  assign accept     = word_valid && !word_stall;
  assign sum_w      = running_sum + word.data_word;

  always_ff @(posedge clk) begin
    if (rst) begin
      sync_word      <= SYNC_WORD_RESET;
      signature_word <= SIGNATURE_WORD_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SYNC_WORD:      sync_word      <= cfg_data;
        REG_SIGNATURE_WORD: signature_word <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    phase_cur         = word.buffer_first ? PH_SYNC : phase;
    count_cur         = word.buffer_first ? '0 : count;
    phase_next        = phase_cur;
    count_next        = count_cur;
    expected_sum_next = expected_sum;
    running_sum_next  = running_sum;
    held_x_next       = held_x;
    held_y_next       = held_y;
    held_height_next  = held_height;
    result_next       = '0;
    unique case (phase_cur)
      PH_SYNC: begin
        if (word.data_word == sync_word) phase_next = PH_CHECK;
      end
      PH_CHECK: begin
        if (word.data_word != sync_word) begin
          expected_sum_next = word.data_word;
          phase_next        = PH_SIG;
        end
      end
      PH_SIG: begin
        if (word.data_word == signature_word) begin
          running_sum_next = word.data_word;
          phase_next       = PH_X;
        end else begin
          phase_next = PH_SYNC;
        end
      end
      PH_X: begin
        running_sum_next = sum_w;
        held_x_next      = word.data_word;
        phase_next       = PH_Y;
      end
      PH_Y: begin
        running_sum_next = sum_w;
        held_y_next      = word.data_word;
        phase_next       = PH_H;
      end
      PH_H: begin
        running_sum_next = sum_w;
        held_height_next = word.data_word;
        phase_next       = PH_W;
      end
      PH_W: begin
        running_sum_next = sum_w;
        if (sum_w == expected_sum && count_cur < COUNT_W'(MAX_OBJECTS)) begin
          result_next.object_valid = 1'b1;
          result_next.object_index = count_cur;
          result_next.pos_x        = held_x;
          result_next.pos_y        = held_y;
          result_next.obj_height   = held_height;
          result_next.obj_width    = word.data_word;
          count_next               = count_cur + COUNT_W'(1);
        end
        phase_next = PH_SYNC;
      end
      default: phase_next = PH_SYNC;
    endcase
    result_next.buffer_done = word.buffer_last;
    result_next.found_count = count_next;
    emit = result_next.object_valid || word.buffer_last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_SYNC;
      count <= '0;
    end else if (accept) begin
      phase <= phase_next;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      expected_sum <= expected_sum_next;
      running_sum  <= running_sum_next;
      held_x       <= held_x_next;
      held_y       <= held_y_next;
      held_height  <= held_height_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (accept && emit) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && emit) begin
      result <= result_next;
    end
  end

  `CBFP_ASSERT_IMPL(a_count_limit, clk, rst, 1'b1, count <= COUNT_W'(MAX_OBJECTS))
  `CBFP_ASSERT_IMPL(a_index_matches_count, clk, rst,
    result_valid && result.object_valid,
    result.object_index + COUNT_W'(1) == result.found_count)
  `CBFP_ASSERT_IMPL(a_plain_result_is_done, clk, rst,
    result_valid && !result.object_valid, result.buffer_done)
  `CBFP_ASSERT_NEXT(a_first_clears_count, clk, rst,
    accept && word.buffer_first, count <= COUNT_W'(1))

endmodule

FILE: bench/tb_top.sv
module tb_top
  import cbfp_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  typedef enum int {FRAME_GOOD, FRAME_BAD_SUM, FRAME_BAD_SIG, FRAME_CUT} frame_flaw_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   word_valid = 1'b0;
  logic                   word_stall;
  word_t                  word_bus = '0;
  logic                   result_valid;
  logic                   result_stall = 1'b0;
  result_t                result_bus;
  logic                   cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = REG_SYNC_WORD;
  logic [WORD_W-1:0]      cfg_data = '0;

  bit idle_on = 1'b1;
  bit stall_on = 1'b1;
  int errors = 0;
  int words_sent = 0;

  logic [WORD_W-1:0]  sync_reg = SYNC_WORD_RESET;
  logic [WORD_W-1:0]  sig_reg = SIGNATURE_WORD_RESET;
  phase_t             phase = PH_SYNC;
  logic [WORD_W-1:0]  want_sum = '0;
  logic [WORD_W-1:0]  run_sum = '0;
  logic [COUNT_W-1:0] obj_count = '0;
  logic [WORD_W-1:0]  keep_x = '0;
  logic [WORD_W-1:0]  keep_y = '0;
  logic [WORD_W-1:0]  keep_h = '0;

  result_t object_reports[$];
  result_t want_report;

  camera_block_frame_parser_core u_dut (
    .clk          (clk),
    .rst          (rst),
    .word_valid   (word_valid),
    .word_stall   (word_stall),
    .word         (word_bus),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result_bus),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #10 clk = ~clk;

  always @(negedge clk) begin
    result_stall <= stall_on && ($urandom_range(99) < 38);
  end

  function automatic void clear_parser();
    phase = PH_SYNC;
    want_sum = '0;
    run_sum = '0;
    obj_count = '0;
    keep_x = '0;
    keep_y = '0;
    keep_h = '0;
  endfunction

  function automatic bit parse_word(input word_t w, output result_t r);
    bit hit = 1'b0;
    r = '0;
    if (w.buffer_first) clear_parser();
    case (phase)
      PH_SYNC: begin
        if (w.data_word == sync_reg) phase = PH_CHECK;
      end
      PH_CHECK: begin
        if (w.data_word != sync_reg) begin
          want_sum = w.data_word;
          phase = PH_SIG;
        end
      end
      PH_SIG: begin
        if (w.data_word == sig_reg) begin
          run_sum = w.data_word;
          phase = PH_X;
        end else begin
          phase = PH_SYNC;
        end
      end
      PH_X: begin
        run_sum = run_sum + w.data_word;
        keep_x = w.data_word;
        phase = PH_Y;
      end
      PH_Y: begin
        run_sum = run_sum + w.data_word;
        keep_y = w.data_word;
        phase = PH_H;
      end
      PH_H: begin
        run_sum = run_sum + w.data_word;
        keep_h = w.data_word;
        phase = PH_W;
      end
      PH_W: begin
        run_sum = run_sum + w.data_word;
        if (run_sum == want_sum && obj_count < COUNT_W'(MAX_OBJECTS)) begin
          hit = 1'b1;
          r.object_valid = 1'b1;
          r.object_index = obj_count;
          r.pos_x = keep_x;
          r.pos_y = keep_y;
          r.obj_height = keep_h;
          r.obj_width = w.data_word;
          obj_count = obj_count + COUNT_W'(1);
        end
        phase = PH_SYNC;
      end
      default: phase = PH_SYNC;
    endcase
    r.buffer_done = w.buffer_last;
    r.found_count = obj_count;
    return hit || w.buffer_last;
  endfunction

  function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %h actual %h", $time, name, want, got);
      errors++;
    end
  endfunction

  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) begin
      if (object_reports.size() == 0) begin
        $display("%0t: unexpected result expected none actual %p", $time, result_bus);
        errors++;
      end else begin
        want_report = object_reports.pop_front();
        check_field("object_valid", 16'(want_report.object_valid),
                    16'(result_bus.object_valid));
        check_field("object_index", 16'(want_report.object_index),
                    16'(result_bus.object_index));
        check_field("pos_x", want_report.pos_x, result_bus.pos_x);
        check_field("pos_y", want_report.pos_y, result_bus.pos_y);
        check_field("obj_height", want_report.obj_height, result_bus.obj_height);
        check_field("obj_width", want_report.obj_width, result_bus.obj_width);
        check_field("buffer_done", 16'(want_report.buffer_done),
                    16'(result_bus.buffer_done));
        check_field("found_count", 16'(want_report.found_count),
                    16'(result_bus.found_count));
      end
    end
  end

  function automatic word_t make_word(logic [15:0] data, bit first, bit last);
    word_t w;
    w.data_word = data;
    w.buffer_first = first;
    w.buffer_last = last;
    return w;
  endfunction

  task automatic send_word(input word_t w);
    result_t r;
    if (idle_on && $urandom_range(99) < 38) begin
      word_valid <= 1'b0;
      repeat ($urandom_range(1, 2)) @(negedge clk);
    end
    word_bus <= w;
    word_valid <= 1'b1;
    @(posedge clk);
    while (word_stall) @(posedge clk);
    if (parse_word(w, r)) object_reports.push_back(r);
    words_sent++;
    @(negedge clk);
  endtask

  task automatic send_all(input word_t q[$]);
    foreach (q[i]) send_word(q[i]);
  endtask

  task automatic drain();
    word_valid <= 1'b0;
    while (object_reports.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [WORD_W-1:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    if (idx == REG_SYNC_WORD) sync_reg = value;
    else sig_reg = value;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  function automatic void add_frame(ref word_t q[$], input frame_flaw_t flaw);
    logic [15:0] x, y, h, wd, total, sig;
    x = 16'($urandom);
    y = 16'($urandom);
    h = 16'($urandom);
    wd = 16'($urandom);
    total = sig_reg + x + y + h + wd;
    if (flaw == FRAME_BAD_SUM) total = total ^ 16'($urandom_range(1, 16'hFFFF));
    sig = sig_reg;
    if (flaw == FRAME_BAD_SIG) sig = sig ^ 16'($urandom_range(1, 16'hFFFF));
    q.push_back(make_word(sync_reg, 1'b0, 1'b0));
    if ($urandom_range(9) == 0) begin
      repeat ($urandom_range(1, 2)) q.push_back(make_word(sync_reg, 1'b0, 1'b0));
    end
    q.push_back(make_word(total, 1'b0, 1'b0));
    q.push_back(make_word(sig, 1'b0, 1'b0));
    q.push_back(make_word(x, 1'b0, 1'b0));
    q.push_back(make_word(y, 1'b0, 1'b0));
    q.push_back(make_word(h, 1'b0, 1'b0));
    q.push_back(make_word(wd, 1'b0, 1'b0));
    if (flaw == FRAME_CUT) begin
      repeat ($urandom_range(1, 5)) void'(q.pop_back());
    end
  endfunction

  function automatic word_t noise_word();
    return make_word(16'($urandom), $urandom_range(99) < 3, $urandom_range(99) < 4);
  endfunction

  task automatic random_buffer(int max_frames);
    word_t q[$];
    int roll;
    repeat ($urandom_range(0, max_frames)) begin
      if ($urandom_range(4) == 0) begin
        repeat ($urandom_range(1, 3)) q.push_back(noise_word());
      end
      roll = $urandom_range(99);
      if (roll < 70) add_frame(q, FRAME_GOOD);
      else if (roll < 80) add_frame(q, FRAME_BAD_SUM);
      else if (roll < 90) add_frame(q, FRAME_BAD_SIG);
      else add_frame(q, FRAME_CUT);
    end
    if (q.size() == 0 || $urandom_range(3) == 0) q.push_back(noise_word());
    if ($urandom_range(9) != 0) q[0].buffer_first = 1'b1;
    q[$].buffer_last = 1'b1;
    send_all(q);
  endtask

  task automatic test_random_buffers(int n);
    int target;
    target = words_sent + n;
    while (words_sent < target) random_buffer(14);
    drain();
  endtask

  task automatic test_directed();
    send_word(make_word(16'hAA55, 1'b1, 1'b0));
    // repeated sync in checksum position is skipped
    send_word(make_word(16'hAA55, 1'b0, 1'b0));
    send_word(make_word(16'hFFFF, 1'b0, 1'b0));
    send_word(make_word(16'h0001, 1'b0, 1'b0));
    send_word(make_word(16'h0000, 1'b0, 1'b0));
    send_word(make_word(16'hFFFF, 1'b0, 1'b0));
    send_word(make_word(16'h0000, 1'b0, 1'b0));
    send_word(make_word(16'hFFFF, 1'b0, 1'b0));
    send_word(make_word(16'h1234, 1'b0, 1'b1));
    // bad checksum, end of buffer on the width word
    send_word(make_word(16'hAA55, 1'b0, 1'b0));
    send_word(make_word(16'h0000, 1'b0, 1'b0));
    send_word(make_word(16'h0001, 1'b0, 1'b0));
    send_word(make_word(16'hFFFF, 1'b0, 1'b0));
    send_word(make_word(16'h0000, 1'b0, 1'b0));
    send_word(make_word(16'hFFFF, 1'b0, 1'b0));
    send_word(make_word(16'h0000, 1'b0, 1'b1));
    // signature mismatch on a sync word does not restart the frame
    send_word(make_word(16'hAA55, 1'b0, 1'b0));
    send_word(make_word(16'h0005, 1'b0, 1'b0));
    send_word(make_word(16'hAA55, 1'b0, 1'b0));
    send_word(make_word(16'h0002, 1'b0, 1'b0));
    // end of buffer mid-frame keeps the parse state
    send_word(make_word(16'hAA55, 1'b0, 1'b1));
    send_word(make_word(16'h0006, 1'b0, 1'b0));
    send_word(make_word(16'h0001, 1'b0, 1'b0));
    // start of buffer mid-frame restarts on this word
    send_word(make_word(16'hAA55, 1'b1, 1'b0));
    send_word(make_word(16'hAA55, 1'b0, 1'b1));
    drain();
  endtask

  task automatic test_object_limit();
    word_t q[$];
    repeat (MAX_OBJECTS + 2) add_frame(q, FRAME_GOOD);
    q[0].buffer_first = 1'b1;
    q[$].buffer_last = 1'b1;
    send_all(q);
    drain();
  endtask

  task automatic test_back_to_back(int n);
    idle_on = 1'b0;
    stall_on = 1'b0;
    test_random_buffers(n);
    idle_on = 1'b1;
    stall_on = 1'b1;
  endtask

  task automatic test_register_sweep(int n);
    logic [15:0] shared;
    write_reg(REG_SYNC_WORD, 16'h0000);
    write_reg(REG_SIGNATURE_WORD, 16'hFFFF);
    test_random_buffers(n);
    write_reg(REG_SYNC_WORD, 16'hFFFF);
    write_reg(REG_SIGNATURE_WORD, 16'h0000);
    test_random_buffers(n);
    write_reg(REG_SYNC_WORD, 16'($urandom));
    write_reg(REG_SIGNATURE_WORD, 16'($urandom));
    test_random_buffers(n);
    shared = 16'($urandom);
    write_reg(REG_SYNC_WORD, shared);
    write_reg(REG_SIGNATURE_WORD, shared);
    test_random_buffers(n);
    write_reg(REG_SYNC_WORD, SYNC_WORD_RESET);
    write_reg(REG_SIGNATURE_WORD, SIGNATURE_WORD_RESET);
    test_random_buffers(n / 2);
  endtask

  initial begin
    clear_parser();
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_directed();
    test_object_limit();
    test_random_buffers(420);
    test_back_to_back(200);
    test_register_sweep(180);
    drain();
    if (errors == 0) begin
      $display("camera_block_frame_parser_core: match");
    end else begin
      $display("camera_block_frame_parser_core: mismatch");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("camera_block_frame_parser_core: mismatch");
    $finish;
  end

endmodule
